// File: hdl/pvr_pkg.sv
package pvr_pkg;

  // defaults for the top-level parameters
  localparam int unsigned CordicStagesDef = 24;
  localparam int unsigned CoordWidthDef   = 32;

  // arctangent table depth
  localparam int unsigned AtanLen = 32;

  // datapath widths: 48-bit gain-scaled coordinate plus growth, 33-bit residual angle
  localparam int unsigned AccW = 50;
  localparam int unsigned ResW = 33;

  // 1/K in Q0.32 and 2^31/pi
  localparam logic [31:0] InvGain   = 32'd2608131496;
  localparam logic [31:0] RadToTurn = 32'd683565276;

  // degree reduction: 360 deg in Q16.16 is 45 * 2^19
  localparam logic signed [13:0] DegBias    = 14'sd4140;   // 92 * 45
  localparam logic [19:0]        Div45Mul   = 20'd745655;  // ceil(2^25 / 45)
  localparam int unsigned        Div45Shift = 25;
  localparam logic [31:0]        TurnPer45  = 32'd95443717; // floor(2^32 / 45)
  localparam logic [18:0]        TurnRem45  = 19'd31;       // 2^32 mod 45
  localparam logic [18:0]        DegRound   = 19'd22;

  // exact quotient by 45 for any 19-bit value
  function automatic logic [13:0] div45(input logic [18:0] v);
    logic [38:0] p;
    p = 39'(v) * 39'(Div45Mul);
    return p[38:Div45Shift];
  endfunction

  // arctangent of 2^-i in binary-angle units (2^32 per turn)
  function automatic logic [29:0] atan_turn(input logic [4:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10679838;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      5'd24: r = 30'd41;
      5'd25: r = 30'd20;
      5'd26: r = 30'd10;
      5'd27: r = 30'd5;
      5'd28: r = 30'd3;
      5'd29: r = 30'd1;
      5'd30: r = 30'd1;
      5'd31: r = 30'd0;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/planar_vector_rotate.sv
// channel   dir  signals                        payload
// s_axis    in   tvalid tready tdata tuser      tdata: x_in, y_in, angle; tuser: in_degrees, clockwise
// m_axis    out  tvalid tready tdata            tdata: x_out, y_out
//
// one transaction per cycle sustained while m_axis_tready is high
// five setup stages (gain multiply, degree/radian to binary angle, quadrant fold),
// one register per CORDIC iteration, one rounding/saturation stage
// reset clears the stage valid bits only
// each stage moves when it is empty or the next one moves, so bubbles are squeezed out
// and a stalled output keeps taking input until every stage is full
module planar_vector_rotate #(
  parameter int unsigned CORDIC_STAGES = pvr_pkg::CordicStagesDef,
  parameter int unsigned COORD_WIDTH   = pvr_pkg::CoordWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [95:0] s_axis_tdata_i,   // x_in[31:0], y_in[63:32], angle[95:64]
  input  logic [1:0]  s_axis_tuser_i,   // in_degrees[0], clockwise[1]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o    // x_out[31:0], y_out[63:32]
);

  localparam int unsigned NumIter   = (CORDIC_STAGES > pvr_pkg::AtanLen) ?
                                      pvr_pkg::AtanLen : CORDIC_STAGES;
  localparam int unsigned NumPre    = 5;
  localparam int unsigned NumStages = NumPre + NumIter + 1;
  localparam int unsigned SatW      = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam int unsigned AW        = pvr_pkg::AccW;
  localparam int unsigned ZW        = pvr_pkg::ResW;
  localparam int unsigned RW        = AW - 16;

  localparam logic signed [RW-1:0] SatHi = RW'((64'sd1 <<< (SatW - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] SatLo = -SatHi - RW'(1);

  // handshake and stage advance
  logic [NumStages-1:0] vld_q;
  logic [NumStages:0]   adv;

  assign adv[NumStages] = m_axis_tready_i;

  for (genvar k = 0; k < NumStages; k++) begin : g_adv
    assign adv[k] = ~vld_q[k] | adv[k+1];
  end

  assign s_axis_tready_o = adv[0];
  assign m_axis_tvalid_o = vld_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= s_axis_tvalid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // field unpacking
  logic signed [31:0] x_in;
  logic signed [31:0] y_in;
  logic signed [31:0] angle;
  logic               in_degrees;
  logic               clockwise;

  assign x_in       = s_axis_tdata_i[31:0];
  assign y_in       = s_axis_tdata_i[63:32];
  assign angle      = s_axis_tdata_i[95:64];
  assign in_degrees = s_axis_tuser_i[0];
  assign clockwise  = s_axis_tuser_i[1];

  // stage 1: gain and radian products, quotients by 45 for the degree path
  logic signed [63:0] xp_d, yp_d, radp_d;
  logic signed [13:0] h_ext;
  logic [13:0]        vh_d, qh_full, lhi_d;
  logic signed [63:0] xp_q, yp_q;
  logic [47:0]        radp_q;
  logic [13:0]        vh_q, lhi_q;
  logic [7:0]         qh_q;
  logic [18:0]        low_q;
  logic               deg1_q, cw1_q;

  always_comb begin
    xp_d    = $signed(x_in) * $signed({1'b0, pvr_pkg::InvGain});
    yp_d    = $signed(y_in) * $signed({1'b0, pvr_pkg::InvGain});
    radp_d  = $signed(angle) * $signed({1'b0, pvr_pkg::RadToTurn});
    // upper bits of the angle, biased by a multiple of 45 to stay non-negative
    h_ext   = {angle[31], angle[31:19]};
    vh_d    = 14'(h_ext + pvr_pkg::DegBias);
    qh_full = pvr_pkg::div45({5'b0, vh_d});
    lhi_d   = pvr_pkg::div45(angle[18:0]);
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      xp_q   <= xp_d;
      yp_q   <= yp_d;
      radp_q <= radp_d[47:0];
      vh_q   <= vh_d;
      qh_q   <= qh_full[7:0];
      low_q  <= angle[18:0];
      lhi_q  <= lhi_d;
      deg1_q <= in_degrees;
      cw1_q  <= clockwise;
    end
  end

  // stage 2: remainders, gain rounding, radian angle rounding
  logic [13:0]        qh45;
  logic [18:0]        lhi45;
  logic signed [63:0] xg_sum, yg_sum;
  logic [47:0]        rad_sum;
  logic signed [47:0] xg_q, yg_q;
  logic [31:0]        thr_q;
  logic [5:0]         rh_q, lrem_q;
  logic [13:0]        lhi2_q;
  logic               deg2_q, cw2_q;

  always_comb begin
    qh45    = 14'({6'b0, qh_q} * 14'd45);
    lhi45   = 19'({5'b0, lhi_q} * 19'd45);
    xg_sum  = xp_q + 64'sd32768;
    yg_sum  = yp_q + 64'sd32768;
    rad_sum = radp_q + 48'h8000;
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      xg_q   <= xg_sum[63:16];
      yg_q   <= yg_sum[63:16];
      thr_q  <= rad_sum[47:16];
      rh_q   <= 6'(vh_q - qh45);
      lrem_q <= 6'(low_q - lhi45);
      lhi2_q <= lhi_q;
      deg2_q <= deg1_q;
      cw2_q  <= cw1_q;
    end
  end

  // stage 3: pieces of floor((r * 2^16 + 180) / 360)
  logic [18:0]        n3;
  logic [13:0]        q3_d;
  logic [31:0]        thh_q;
  logic [13:0]        q3_q, lhi3_q;
  logic [31:0]        thr3_q;
  logic signed [47:0] xg3_q, yg3_q;
  logic               deg3_q, cw3_q;

  always_comb begin
    n3   = {lrem_q, 13'b0} + 19'({13'b0, rh_q} * pvr_pkg::TurnRem45) + pvr_pkg::DegRound;
    q3_d = pvr_pkg::div45(n3);
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      thh_q  <= 32'({26'b0, rh_q} * pvr_pkg::TurnPer45);
      q3_q   <= q3_d;
      lhi3_q <= lhi2_q;
      thr3_q <= thr_q;
      xg3_q  <= xg_q;
      yg3_q  <= yg_q;
      deg3_q <= deg2_q;
      cw3_q  <= cw2_q;
    end
  end

  // stage 4: select the binary angle and apply the direction
  logic [31:0]        thd, th_sel;
  logic [31:0]        th4_q;
  logic signed [47:0] xg4_q, yg4_q;

  always_comb begin
    thd    = thh_q + {5'b0, lhi3_q, 13'b0} + {18'b0, q3_q};
    th_sel = deg3_q ? thd : thr3_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      th4_q <= cw3_q ? (32'd0 - th_sel) : th_sel;
      xg4_q <= xg3_q;
      yg4_q <= yg3_q;
    end
  end

  // stage 5: fold the second and third quadrants by a half turn
  logic signed [AW-1:0] cx_q [0:NumIter];
  logic signed [AW-1:0] cy_q [0:NumIter];
  logic signed [ZW-1:0] cz_q [0:NumIter];
  logic signed [AW-1:0] xe, ye;
  logic                 fold;
  logic [31:0]          th_f;

  always_comb begin
    xe   = {{(AW-48){xg4_q[47]}}, xg4_q};
    ye   = {{(AW-48){yg4_q[47]}}, yg4_q};
    fold = th4_q[31] ^ th4_q[30];
    th_f = fold ? {~th4_q[31], th4_q[30:0]} : th4_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      cx_q[0] <= fold ? -xe : xe;
      cy_q[0] <= fold ? -ye : ye;
      cz_q[0] <= {th_f[31], th_f};
    end
  end

  // cordic iterations, one per stage
  for (genvar i = 0; i < NumIter; i++) begin : g_iter
    logic signed [AW-1:0] dx, dy;
    logic signed [ZW-1:0] atn;

    always_comb begin
      dx  = cy_q[i] >>> i;
      dy  = cx_q[i] >>> i;
      atn = $signed({3'b0, pvr_pkg::atan_turn(5'(i))});
    end

    always_ff @(posedge clk_i) begin
      if (adv[NumPre+i]) begin
        if (!cz_q[i][ZW-1]) begin
          cx_q[i+1] <= cx_q[i] - dx;
          cy_q[i+1] <= cy_q[i] + dy;
          cz_q[i+1] <= cz_q[i] - atn;
        end else begin
          cx_q[i+1] <= cx_q[i] + dx;
          cy_q[i+1] <= cy_q[i] - dy;
          cz_q[i+1] <= cz_q[i] + atn;
        end
      end
    end
  end

  // output stage: drop guard bits with rounding, then saturate
  function automatic logic [31:0] sat_out(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] c;
    priority if (v > SatHi) begin
      c = SatHi;
    end else if (v < SatLo) begin
      c = SatLo;
    end else begin
      c = v;
    end
    return 32'(c);
  endfunction

  logic signed [AW-1:0] xr_sum, yr_sum;
  logic [31:0]          xo_q, yo_q;

  always_comb begin
    xr_sum = cx_q[NumIter] + AW'(32768);
    yr_sum = cy_q[NumIter] + AW'(32768);
  end

  always_ff @(posedge clk_i) begin
    if (adv[NumStages-1]) begin
      xo_q <= sat_out(xr_sum[AW-1:16]);
      yo_q <= sat_out(yr_sum[AW-1:16]);
    end
  end

  assign m_axis_tdata_o = {yo_q, xo_q};

  // the residual angle of the last iteration is not needed at the output
  logic unused_z;
  assign unused_z = ^cz_q[NumIter];

endmodule
